[rtl/mbs_pkg.sv]
// ============================================================================
// mbs_pkg
// Shared types and constants of the multipart boundary splitter.
// ============================================================================
package mbs_pkg;

    // Boundary table depth and the width of a match position (up to the depth)
    localparam int BOUNDARY_MAX = 48;
    localparam int POS_W        = 6;

    localparam logic [POS_W-1:0] LEN_MIN = POS_W'(4);
    localparam logic [POS_W-1:0] LEN_MAX = POS_W'(BOUNDARY_MAX);
    localparam logic [POS_W-1:0] LEN_RST = POS_W'(4);

    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_CR   = 8'h0D;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_STREAM  = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_HDR_BYTE   = 3'd0,
        KIND_DATA_BYTE  = 3'd1,
        KIND_LINE_END   = 3'd2,
        KIND_DATA_BEGIN = 3'd3,
        KIND_PART_END   = 3'd4,
        KIND_FORM_END   = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REPLAY,
        ST_TAIL
    } state_t;

    // Effect of one ordinary (non-matching) byte
    typedef struct packed {
        logic       emit;
        kind_t      kind;
        logic [7:0] data;
        logic       in_header;
        logic       line_text;
        logic       rematch;
    } ord_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

[rtl/mbs_ram.sv]
// ============================================================================
// mbs_ram
// Single-port-write, single-port-read synchronous RAM with a registered
// read, write-first on a same-address collision.
// ============================================================================
module mbs_ram #(
    parameter int DEPTH  = 48,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en && (32'(wr_addr) < DEPTH))
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Forward the word being written so a read never sees stale data
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else if (32'(rd_addr) < DEPTH)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/multipart_boundary_splitter.sv]
// ============================================================================
// multipart_boundary_splitter
// Splits a multipart form byte stream at a loaded boundary string.
//
// Load the boundary (newline, two dashes, token) one character per
// transaction with cmd 0, set boundary_length through the configuration
// port, then stream bytes with cmd 1; cmd 2 restarts for a new form and
// keeps the table. Bytes that could start the boundary are held back; on a
// mismatch they are replayed as header or data bytes before the byte that
// broke the match. Results carry a kind on m_tuser and tlast marks the final
// result of each input transaction. Rate: one cycle per input transaction
// whenever the output register is free and no replay is under way. After a
// mismatch with held bytes the block accepts the breaking byte, replays each
// held byte in turn through the single read port of the boundary table
// memory, then handles the breaking byte as ordinary, taking no new input
// meanwhile; output stalls hold it up. The table is not cleared after reset,
// so the block accepts transactions right away.
// ============================================================================
module multipart_boundary_splitter (
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration: boundary_length
    input  logic                    cfg_wr_en,
    input  logic [mbs_pkg::POS_W-1:0] cfg_wr_data,
    // input stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [15:0]             s_tdata,   // [5:0] char_index, [13:6] byte_in
    input  logic [1:0]              s_tuser,   // [1:0] cmd
    // result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [7:0]              m_tdata,   // [7:0] byte_out
    output logic [2:0]              m_tuser,   // [2:0] kind
    output logic                    m_tlast
);

    import mbs_pkg::*;

    // Ordinary-byte handling: plain bytes, header line ends, blank line, data newlines
    function automatic ord_t ordinary_f(
        input logic [7:0] c,
        input logic       hdr,
        input logic       txt
    );
        ord_t r;
        r.emit      = 1'b1;
        r.kind      = hdr ? KIND_HDR_BYTE : KIND_DATA_BYTE;
        r.data      = c;
        r.in_header = hdr;
        r.line_text = txt | (hdr & ~is_ws(c));
        r.rematch   = 1'b0;
        if (c == CH_NL)
        begin
            r.data      = 8'd0;
            r.line_text = txt;
            if (hdr && !txt)
            begin
                // blank header line: data begins, no boundary match starts
                r.kind      = KIND_DATA_BEGIN;
                r.in_header = 1'b0;
            end
            else if (hdr)
            begin
                r.kind      = KIND_LINE_END;
                r.line_text = 1'b0;
                r.rematch   = 1'b1;
            end
            else
            begin
                r.emit    = 1'b0;
                r.rematch = 1'b1;
            end
        end
        return r;
    endfunction

    // Input fields
    cmd_t             in_cmd;
    logic [POS_W-1:0] in_index;
    logic [7:0]       in_byte;
    logic             in_accept;

    assign in_cmd    = cmd_t'(s_tuser);
    assign in_index  = s_tdata[5:0];
    assign in_byte   = s_tdata[13:6];
    assign in_accept = s_tvalid && s_tready;

    // Control state
    state_t           state_reg,     state_next;
    logic [POS_W-1:0] pos_reg,       pos_next;
    logic [POS_W-1:0] k_reg,         k_next;
    logic [POS_W-1:0] len_reg;
    logic             matching_reg,  matching_next;
    logic             in_header_reg, in_header_next;
    logic             line_text_reg, line_text_next;
    logic             form_done_reg, form_done_next;
    logic             first_reg,     first_next;
    logic [7:0]       held_reg,      held_next;

    // Output register
    logic             m_valid_reg;
    kind_t            m_kind_reg;
    logic [7:0]       m_byte_reg;
    logic             m_last_reg;
    logic             out_free;

    logic             emit;
    kind_t            emit_kind;
    logic [7:0]       emit_byte;
    logic             emit_last;

    // Table memory
    logic             ram_we;
    logic [POS_W-1:0] ram_raddr;
    logic [7:0]       ram_rdata;

    logic [POS_W-1:0] used_len;
    logic [POS_W-1:0] pos_last;
    logic [POS_W-1:0] k_start;
    logic [7:0]       ord_byte;
    logic [7:0]       replay_byte;
    ord_t             ord;

    assign out_free = !m_valid_reg || m_tready;

    // Saturate the length into its legal range
    assign used_len = (len_reg < LEN_MIN) ? LEN_MIN :
                      (len_reg > LEN_MAX) ? LEN_MAX : len_reg;

    assign pos_last    = pos_reg - POS_W'(1);
    assign k_start     = {{(POS_W-1){1'b0}}, first_reg};
    assign ord_byte    = (state_reg == ST_IDLE) ? in_byte : held_reg;
    assign replay_byte = (k_reg == '0) ? CH_NL : ram_rdata;
    assign ord         = ordinary_f(ord_byte, in_header_reg, line_text_reg);

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        matching_next  = matching_reg;
        in_header_next = in_header_reg;
        line_text_next = line_text_reg;
        form_done_next = form_done_reg;
        first_next     = first_reg;
        held_next      = held_reg;
        emit           = 1'b0;
        emit_kind      = KIND_HDR_BYTE;
        emit_byte      = 8'd0;
        emit_last      = 1'b1;
        s_tready       = 1'b0;
        ram_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = out_free;
                if (in_accept)
                begin
                    unique case (in_cmd)
                        CMD_LOAD:
                        begin
                            ram_we = 1'b1;
                        end
                        CMD_RESTART:
                        begin
                            pos_next       = POS_W'(1);
                            matching_next  = 1'b1;
                            in_header_next = 1'b0;
                            line_text_next = 1'b0;
                            form_done_next = 1'b0;
                            first_next     = 1'b1;
                        end
                        CMD_STREAM:
                        begin
                            if (!form_done_reg)
                            begin
                                if (!matching_reg)
                                begin
                                    emit           = ord.emit;
                                    emit_kind      = ord.kind;
                                    emit_byte      = ord.data;
                                    in_header_next = ord.in_header;
                                    line_text_next = ord.line_text;
                                    if (ord.rematch)
                                    begin
                                        matching_next = 1'b1;
                                        pos_next      = POS_W'(1);
                                        first_next    = 1'b0;
                                    end
                                end
                                else if (pos_reg >= used_len)
                                begin
                                    // full match: dash ends the form, newline the part
                                    if (in_byte == CH_DASH)
                                    begin
                                        emit           = 1'b1;
                                        emit_kind      = KIND_FORM_END;
                                        form_done_next = 1'b1;
                                        matching_next  = 1'b0;
                                        first_next     = 1'b0;
                                    end
                                    else if (in_byte == CH_NL)
                                    begin
                                        emit           = 1'b1;
                                        emit_kind      = KIND_PART_END;
                                        in_header_next = 1'b1;
                                        line_text_next = 1'b0;
                                        matching_next  = 1'b0;
                                        first_next     = 1'b0;
                                    end
                                end
                                else if (ram_rdata == in_byte)
                                begin
                                    pos_next = pos_reg + POS_W'(1);
                                end
                                else
                                begin
                                    matching_next = 1'b0;
                                    first_next    = 1'b0;
                                    if (k_start < pos_reg)
                                    begin
                                        // replay the held characters first
                                        state_next = ST_REPLAY;
                                        k_next     = k_start;
                                        held_next  = in_byte;
                                    end
                                    else
                                    begin
                                        emit           = ord.emit;
                                        emit_kind      = ord.kind;
                                        emit_byte      = ord.data;
                                        in_header_next = ord.in_header;
                                        line_text_next = ord.line_text;
                                        if (ord.rematch)
                                        begin
                                            matching_next = 1'b1;
                                            pos_next      = POS_W'(1);
                                        end
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            // unknown command: drop
                        end
                    endcase
                end
            end

            ST_REPLAY:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_kind = in_header_reg ? KIND_HDR_BYTE : KIND_DATA_BYTE;
                    emit_byte = replay_byte;
                    emit_last = (k_reg == pos_last) && !ord.emit;
                    if (in_header_reg && !is_ws(replay_byte))
                    begin
                        line_text_next = 1'b1;
                    end
                    k_next = k_reg + POS_W'(1);
                    if (k_reg == pos_last)
                    begin
                        state_next = ST_TAIL;
                    end
                end
            end

            ST_TAIL:
            begin
                // the byte that broke the match, handled as ordinary
                if (out_free || !ord.emit)
                begin
                    emit           = ord.emit;
                    emit_kind      = ord.kind;
                    emit_byte      = ord.data;
                    in_header_next = ord.in_header;
                    line_text_next = ord.line_text;
                    if (ord.rematch)
                    begin
                        matching_next = 1'b1;
                        pos_next      = POS_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Prefetch the table entry needed next cycle
    assign ram_raddr = (state_next == ST_REPLAY) ? k_next : pos_next;

    mbs_ram #(
        .DEPTH  (BOUNDARY_MAX),
        .WIDTH  (8),
        .ADDR_W (POS_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (in_index),
        .wr_data (in_byte),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= POS_W'(1);
            k_reg         <= '0;
            matching_reg  <= 1'b1;
            in_header_reg <= 1'b0;
            line_text_reg <= 1'b0;
            form_done_reg <= 1'b0;
            first_reg     <= 1'b1;
            len_reg       <= LEN_RST;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            k_reg         <= k_next;
            matching_reg  <= matching_next;
            in_header_reg <= in_header_next;
            line_text_reg <= line_text_next;
            form_done_reg <= form_done_next;
            first_reg     <= first_next;
            if (cfg_wr_en)
            begin
                len_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

    // Output register: load a new result, or drop the one just taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            m_kind_reg <= emit_kind;
            m_byte_reg <= emit_byte;
            m_last_reg <= emit_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule
